/* src/bps_pkg.sv */
`timescale 1ns / 1ps

package bps_pkg;

    localparam int ELEM_W      = 16;
    localparam int DIFF_W      = 21;
    localparam int MASK_OUT_W  = 16;
    localparam int COUNT_OUT_W = 5;
    localparam int ACC_W       = 22;

    typedef struct packed {
        logic signed [ELEM_W-1:0] element_value;
        logic                     last_element;
    } in_item_t;

    typedef struct packed {
        logic [DIFF_W-1:0]      min_difference;
        logic [MASK_OUT_W-1:0]  best_split_mask;
        logic [COUNT_OUT_W-1:0] element_count;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_INIT,
        ST_PREP,
        ST_EVAL,
        ST_DRAIN,
        ST_UPDATE,
        ST_EMIT
    } search_state_t;

endpackage

/* src/bps_elem_mem.sv */
`timescale 1ns / 1ps

module bps_elem_mem
    import bps_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  logic [ELEM_W-1:0] wr_data,
    input  logic [AW-1:0]     rd_addr,
    output logic [ELEM_W-1:0] rd_data
);

    logic [ELEM_W-1:0] mem [DEPTH];
    logic [ELEM_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* src/bps_comb_step.sv */
`timescale 1ns / 1ps

module bps_comb_step
    import bps_pkg::*;
#(
    parameter int WW = 17,
    parameter int CW = 5
) (
    input  logic [WW-1:0] word,
    input  logic [CW-1:0] count,
    output logic [WW-1:0] next_word,
    output logic          exhausted
);

    logic [WW-1:0] lowest;
    logic [WW-1:0] ripple;
    logic [WW-1:0] tail;
    logic [WW-1:0] result;
    int            tz;

    always_comb begin
        lowest = word & (~word + WW'(1));
        ripple = word + lowest;
        tz     = 0;
        for (int b = WW - 1; b >= 0; b--) begin
            if (word[b]) begin
                tz = b;
            end
        end
        tail      = ((ripple ^ word) >> 2) >> tz;
        result    = tail | ripple;
        exhausted = 1'b0;
        for (int b = 0; b < WW; b++) begin
            if (result[b] && (b >= int'(count))) begin
                exhausted = 1'b1;
            end
        end
        next_word = result;
    end

endmodule

/* src/balanced_partition_search_top.sv */
`timescale 1ns / 1ps
// Channel   Direction  Ports                        Payload
// s_        in         s_valid s_ready s_payload    in_item_t  (one element per request)
// m_        out        m_valid m_ready m_payload    out_item_t (one result per set)
//
// Loading takes an element whenever s_valid is high; requests are taken only while loading.
// Search: C(n, floor(n/2)) + 1 candidates (a single one when n = 1), each passing
// ST_PREP, ST_EVAL (one element read per cycle from the single memory read port),
// ST_DRAIN and ST_UPDATE; ST_INIT precedes the search and ST_EMIT follows it.
// Reset: synchronous, active low; no memory clearing pass.
// A finished result waits in the output register; loading of the next set goes on
// meanwhile, and only a second result stalls until the first is taken.

module balanced_partition_search_top
    import bps_pkg::*;
#(
    parameter int MAX_ELEMS = 16
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_payload,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_payload
);

    localparam int AW = $clog2(MAX_ELEMS);
    localparam int CW = $clog2(MAX_ELEMS + 1);
    localparam int WW = MAX_ELEMS + 1;

    search_state_t state_reg, state_next;

    logic [CW-1:0]        count_reg;
    logic [CW-1:0]        n_reg;
    logic [AW-1:0]        j_reg;
    logic [WW-1:0]        cur_w_reg;
    logic [WW-1:0]        sh_reg;
    logic                 bit_d_reg;
    logic                 rd_valid_reg;
    logic                 first_reg;
    logic [ACC_W-1:0]     acc_reg;
    logic [MAX_ELEMS-1:0] cand_mask_reg;
    logic [MAX_ELEMS-1:0] best_mask_reg;
    logic [DIFF_W-1:0]    best_diff_reg;
    logic                 m_valid_reg;
    out_item_t            m_payload_reg;

    logic [CW-1:0]     k;
    logic [CW-1:0]     n_load;
    logic              store_room;
    logic              mem_we;
    logic [AW-1:0]     rd_addr;
    logic [CW-1:0]     rd_index;
    logic [ELEM_W-1:0] rd_data;
    logic [ACC_W-1:0]  elem_ext;
    logic [ACC_W-1:0]  abs_acc;
    logic [DIFF_W-1:0] cand_diff;
    logic [WW-1:0]     ones_k;
    logic [WW-1:0]     w_first;
    logic [WW-1:0]     step_word;
    logic              step_done;
    logic              eval_last;
    logic              out_free;
    logic              emit;
    logic [MAX_ELEMS+MASK_OUT_W-1:0] mask_wide;

    assign k          = n_reg >> 1;
    assign store_room = (count_reg < CW'(MAX_ELEMS));
    assign n_load     = store_room ? count_reg + CW'(1) : count_reg;
    assign rd_index   = n_reg - CW'(1) - CW'(j_reg);
    assign rd_addr    = rd_index[AW-1:0];
    assign eval_last  = (CW'(j_reg) == n_reg - CW'(1));
    assign out_free   = !m_valid_reg || m_ready;
    assign elem_ext   = {{(ACC_W-ELEM_W){rd_data[ELEM_W-1]}}, rd_data};
    assign abs_acc    = acc_reg[ACC_W-1] ? (~acc_reg + ACC_W'(1)) : acc_reg;
    assign cand_diff  = abs_acc[DIFF_W-1:0];
    assign mask_wide  = {{MASK_OUT_W{1'b0}}, best_mask_reg};

    always_comb begin
        for (int b = 0; b < WW; b++) begin
            ones_k[b]  = (b < int'(k));
            w_first[b] = (b >= int'(n_reg) - int'(k)) && (b < int'(n_reg));
        end
    end

    bps_elem_mem #(
        .DEPTH (MAX_ELEMS),
        .AW    (AW)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (s_payload.element_value),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    bps_comb_step #(
        .WW (WW),
        .CW (CW)
    ) u_step (
        .word      (cur_w_reg),
        .count     (n_reg),
        .next_word (step_word),
        .exhausted (step_done)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD: begin
                if (s_valid && s_payload.last_element) begin
                    state_next = ST_INIT;
                end
            end
            ST_INIT:  state_next = ST_PREP;
            ST_PREP:  state_next = ST_EVAL;
            ST_EVAL: begin
                if (eval_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: state_next = ST_UPDATE;
            ST_UPDATE: begin
                if (first_reg ? (k == '0) : step_done) begin
                    state_next = ST_EMIT;
                end else begin
                    state_next = ST_PREP;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    state_next = ST_LOAD;
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    always_comb begin
        s_ready = (state_reg == ST_LOAD);
        mem_we  = (state_reg == ST_LOAD) && s_valid && store_room;
        emit    = (state_reg == ST_EMIT) && out_free;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_LOAD;
            count_reg    <= '0;
            rd_valid_reg <= 1'b0;
            first_reg    <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            rd_valid_reg <= (state_reg == ST_EVAL);
            if (s_valid && s_ready) begin
                count_reg <= s_payload.last_element ? '0 : n_load;
            end
            if (state_reg == ST_INIT) begin
                first_reg <= 1'b1;
            end else if (state_reg == ST_UPDATE) begin
                first_reg <= 1'b0;
            end
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            n_reg <= n_load;
        end
        case (state_reg)
            ST_INIT: begin
                cur_w_reg <= w_first;
            end
            ST_PREP: begin
                sh_reg        <= cur_w_reg;
                j_reg         <= '0;
                acc_reg       <= '0;
                cand_mask_reg <= '0;
            end
            ST_EVAL: begin
                sh_reg    <= sh_reg >> 1;
                bit_d_reg <= sh_reg[0];
                j_reg     <= j_reg + AW'(1);
            end
            ST_UPDATE: begin
                if (first_reg || (cand_diff < best_diff_reg)) begin
                    best_diff_reg <= cand_diff;
                    best_mask_reg <= cand_mask_reg;
                end
                cur_w_reg <= first_reg ? ones_k : step_word;
            end
            default: begin
            end
        endcase
        if (rd_valid_reg) begin
            acc_reg       <= bit_d_reg ? acc_reg + elem_ext : acc_reg - elem_ext;
            cand_mask_reg <= {cand_mask_reg[MAX_ELEMS-2:0], bit_d_reg};
        end
        if (emit) begin
            m_payload_reg.min_difference  <= best_diff_reg;
            m_payload_reg.best_split_mask <= mask_wide[MASK_OUT_W-1:0];
            m_payload_reg.element_count   <= COUNT_OUT_W'(n_reg);
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(MAX_ELEMS))
        else $error("load count beyond store depth");

    a_read_in_set: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EVAL) |-> (rd_index < n_reg))
        else $error("element read outside loaded set");

    a_cand_weight: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_UPDATE) |-> ($countones(cand_mask_reg) == int'(k)))
        else $error("candidate split has wrong group size");

    a_no_load_in_search: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EVAL || state_reg == ST_DRAIN) |-> !mem_we)
        else $error("element write during search");

    a_result_from_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_EMIT))
        else $error("result raised outside emit");

endmodule
